### design/tuvwf_pkg.sv
package tuvwf_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int FixesWidth = 19;
  localparam int NumRegs    = 8;
  localparam int CfgIdxWidth = 3;

  localparam int WideWidth  = CoordWidth + 1;
  localparam int DistWidth  = CoordWidth + 2;
  localparam int ProdWidth  = 2 * CoordWidth + 2;
  localparam int ShiftWidth = ProdWidth - FracBits;

  localparam logic signed [DistWidth-1:0] OneFx =
    {{(DistWidth-FracBits-1){1'b0}}, 1'b1, {FracBits{1'b0}}};
  localparam logic signed [DistWidth-1:0] HalfFx =
    {{(DistWidth-FracBits){1'b0}}, 1'b1, {(FracBits-1){1'b0}}};
  localparam int LimitInt = ((6 << FracBits) + 5) / 10;
  localparam logic signed [DistWidth-1:0] LimitFx = DistWidth'(LimitInt);

  typedef enum logic [CfgIdxWidth-1:0] {
    TexUScale    = 3'd0,
    TexVScale    = 3'd1,
    TexUOrigin   = 3'd2,
    TexVOrigin   = 3'd3,
    LightUScale  = 3'd4,
    LightVScale  = 3'd5,
    LightUOrigin = 3'd6,
    LightVOrigin = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]                   mode;
    logic signed [CoordWidth-1:0] vert_a_u;
    logic signed [CoordWidth-1:0] vert_a_v;
    logic signed [CoordWidth-1:0] vert_b_u;
    logic signed [CoordWidth-1:0] vert_b_v;
    logic signed [CoordWidth-1:0] vert_c_u;
    logic signed [CoordWidth-1:0] vert_c_v;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                   vertex_index;
    logic signed [CoordWidth-1:0] tex_u_out;
    logic signed [CoordWidth-1:0] tex_v_out;
    logic signed [CoordWidth-1:0] light_u_out;
    logic signed [CoordWidth-1:0] light_v_out;
    logic [FixesWidth-1:0]        face_fixes;
    logic                         last;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxWidth-1:0]       index;
    logic signed [CoordWidth-1:0] data;
  } cfg_word_t;

  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } xf_ctl_t;

endpackage

### design/triangle_uv_wrap_fix_core.sv
// Channel  Direction  Word          Handshake
// in       input      in_word_i     in_valid_i / in_ready_o
// out      output     out_word_o    out_valid_o / out_ready_i
// cfg      input      cfg_word_i    cfg_valid_i / cfg_ready_o (always ready)
//
// A triangle passes two wrap stages, then a vertex sequencer issues its three
// vertices one per cycle, while the multiply stage is free, into a multiply
// stage and a saturating add stage. A triangle is registered at the input and
// after each wrap stage, and each vertex after the multiply and add stages,
// before the single result channel. Reset clears all valid flags and loads the
// configuration registers with their reset values. Every stage holds while the
// next is full and stalled, so new triangles are taken while results wait.
module triangle_uv_wrap_fix_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tuvwf_pkg::in_word_t   in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tuvwf_pkg::out_word_t  out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  tuvwf_pkg::cfg_word_t  cfg_word_i
);

  localparam int W   = tuvwf_pkg::CoordWidth;
  localparam int F   = tuvwf_pkg::FracBits;
  localparam int DW  = tuvwf_pkg::DistWidth;
  localparam int WW  = tuvwf_pkg::WideWidth;
  localparam int FXW = tuvwf_pkg::FixesWidth;
  localparam int NW  = DW - F;
  localparam int SumWidth = (NW + 3 > FXW) ? NW + 3 : FXW;
  localparam logic signed [DW-1:0] RoundUp = tuvwf_pkg::OneFx - DW'(1);
  localparam logic [W-1:0] ResetOne  = tuvwf_pkg::OneFx[W-1:0];
  localparam logic [W-1:0] ResetHalf = tuvwf_pkg::HalfFx[W-1:0];

  logic signed [W-1:0] cfg_q [tuvwf_pkg::NumRegs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[tuvwf_pkg::TexUScale]    <= ResetOne;
      cfg_q[tuvwf_pkg::TexVScale]    <= ResetOne;
      cfg_q[tuvwf_pkg::TexUOrigin]   <= ResetHalf;
      cfg_q[tuvwf_pkg::TexVOrigin]   <= ResetHalf;
      cfg_q[tuvwf_pkg::LightUScale]  <= ResetOne;
      cfg_q[tuvwf_pkg::LightVScale]  <= ResetOne;
      cfg_q[tuvwf_pkg::LightUOrigin] <= ResetHalf;
      cfg_q[tuvwf_pkg::LightVOrigin] <= ResetHalf;
    end else if (cfg_valid_i) begin
      cfg_q[cfg_word_i.index] <= cfg_word_i.data;
    end
  end

  // Pipeline control.
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q;
  logic a_free, b_free, c_free, d_free, e_free;
  logic issue, c_take;
  logic [1:0] idx_q;

  assign e_free = !e_vld_q || out_ready_i;
  assign d_free = !d_vld_q || e_free;
  assign issue  = c_vld_q && d_free;
  assign c_take = issue && (idx_q == 2'd2);
  assign c_free = !c_vld_q || c_take;
  assign b_free = !b_vld_q || c_free;
  assign a_free = !a_vld_q || b_free;
  assign in_ready_o = a_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (a_free) a_vld_q <= in_valid_i;
      if (b_free) b_vld_q <= a_vld_q;
      if (c_free) c_vld_q <= b_vld_q;
      if (d_free) d_vld_q <= c_vld_q;
      if (e_free) e_vld_q <= d_vld_q;
      if (issue) idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
    end
  end

  // Stage A: input word.
  tuvwf_pkg::in_word_t a_q;

  always_ff @(posedge clk_i) begin
    if (a_free && in_valid_i) a_q <= in_word_i;
  end

  // First wrap step: if the axis mode bit is set and every coordinate is at least one, drop the minimum's whole units.
  logic signed [W-1:0] a_crd [2][3];
  logic signed [W-1:0] a_min [2];
  logic                a_drop [2];
  logic signed [W-1:0] b_crd_d [2][3];
  logic signed [W-1:0] b_min_d [2];
  logic signed [W-1:0] b_crd_q [2][3];
  logic signed [W-1:0] b_min_q [2];
  logic [1:0]          b_mode_q;

  assign a_crd[0][0] = a_q.vert_a_u;
  assign a_crd[0][1] = a_q.vert_b_u;
  assign a_crd[0][2] = a_q.vert_c_u;
  assign a_crd[1][0] = a_q.vert_a_v;
  assign a_crd[1][1] = a_q.vert_b_v;
  assign a_crd[1][2] = a_q.vert_c_v;

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      a_min[ax] = a_crd[ax][0];
      if (a_crd[ax][1] < a_min[ax]) a_min[ax] = a_crd[ax][1];
      if (a_crd[ax][2] < a_min[ax]) a_min[ax] = a_crd[ax][2];
      a_drop[ax] = a_q.mode[ax] &&
                   (a_min[ax] >= $signed(tuvwf_pkg::OneFx[W-1:0]));
      for (int i = 0; i < 3; i++) begin
        b_crd_d[ax][i] = a_drop[ax] ?
          a_crd[ax][i] - {a_min[ax][W-1:F], {F{1'b0}}} : a_crd[ax][i];
      end
      b_min_d[ax] = a_drop[ax] ? {{(W-F){1'b0}}, a_min[ax][F-1:0]} : a_min[ax];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_free && a_vld_q) begin
      b_crd_q  <= b_crd_d;
      b_min_q  <= b_min_d;
      b_mode_q <= a_q.mode;
    end
  end

  // Second wrap step: for axes with the mode bit set, pull each coordinate to within the limit of the minimum.
  logic signed [DW-1:0] s2_dist [2][3];
  logic signed [DW-1:0] s2_round [2][3];
  logic                 s2_pos [2][3];
  logic [NW-1:0]        s2_units [2][3];
  logic signed [DW-1:0] s2_crd [2][3];
  logic [SumWidth-1:0]  s2_sum;
  logic signed [WW-1:0] c_crd_d [2][3];
  logic signed [WW-1:0] c_crd_q [2][3];
  logic [FXW-1:0]       c_fix_q;

  always_comb begin
    s2_sum = '0;
    for (int ax = 0; ax < 2; ax++) begin
      for (int i = 0; i < 3; i++) begin
        s2_dist[ax][i] = $signed({{2{b_crd_q[ax][i][W-1]}}, b_crd_q[ax][i]}) -
                         $signed({{2{b_min_q[ax][W-1]}}, b_min_q[ax]}) -
                         tuvwf_pkg::LimitFx;
        s2_pos[ax][i] = b_mode_q[ax] && !s2_dist[ax][i][DW-1] &&
                        (s2_dist[ax][i] != '0);
        s2_round[ax][i] = s2_dist[ax][i] + RoundUp;
        s2_units[ax][i] = s2_pos[ax][i] ? s2_round[ax][i][DW-1:F] : '0;
        s2_crd[ax][i] = $signed({{2{b_crd_q[ax][i][W-1]}}, b_crd_q[ax][i]}) -
                        $signed({s2_units[ax][i], {F{1'b0}}});
        c_crd_d[ax][i] = s2_crd[ax][i][WW-1:0];
        s2_sum = s2_sum + SumWidth'(s2_units[ax][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_free && b_vld_q) begin
      c_crd_q <= c_crd_d;
      c_fix_q <= s2_sum[FXW-1:0];
    end
  end

  // Vertex sequencer select.
  logic signed [WW-1:0] sel_u, sel_v;

  always_comb begin
    case (idx_q)
      2'd1: begin
        sel_u = c_crd_q[0][1];
        sel_v = c_crd_q[1][1];
      end
      2'd2: begin
        sel_u = c_crd_q[0][2];
        sel_v = c_crd_q[1][2];
      end
      default: begin
        sel_u = c_crd_q[0][0];
        sel_v = c_crd_q[1][0];
      end
    endcase
  end

  // Side information that travels with each vertex.
  logic [1:0]     d_idx_q, e_idx_q;
  logic           d_last_q, e_last_q;
  logic [FXW-1:0] d_fix_q, e_fix_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      d_idx_q  <= idx_q;
      d_last_q <= c_take;
      d_fix_q  <= c_take ? c_fix_q : '0;
    end
    if (e_free && d_vld_q) begin
      e_idx_q  <= d_idx_q;
      e_last_q <= d_last_q;
      e_fix_q  <= d_fix_q;
    end
  end

  tuvwf_pkg::xf_ctl_t xf_ctl;

  assign xf_ctl.prod_en = issue;
  assign xf_ctl.sum_en  = e_free && d_vld_q;

  logic signed [W-1:0] tex_u, tex_v, light_u, light_v;

  tuvwf_xform #(.Negate(1'b0)) u_tex_u (
    .clk_i    (clk_i),
    .ctl_i    (xf_ctl),
    .coord_i  (sel_u),
    .scale_i  (cfg_q[tuvwf_pkg::TexUScale]),
    .origin_i (cfg_q[tuvwf_pkg::TexUOrigin]),
    .result_o (tex_u)
  );

  tuvwf_xform #(.Negate(1'b1)) u_tex_v (
    .clk_i    (clk_i),
    .ctl_i    (xf_ctl),
    .coord_i  (sel_v),
    .scale_i  (cfg_q[tuvwf_pkg::TexVScale]),
    .origin_i (cfg_q[tuvwf_pkg::TexVOrigin]),
    .result_o (tex_v)
  );

  tuvwf_xform #(.Negate(1'b0)) u_light_u (
    .clk_i    (clk_i),
    .ctl_i    (xf_ctl),
    .coord_i  (sel_u),
    .scale_i  (cfg_q[tuvwf_pkg::LightUScale]),
    .origin_i (cfg_q[tuvwf_pkg::LightUOrigin]),
    .result_o (light_u)
  );

  tuvwf_xform #(.Negate(1'b1)) u_light_v (
    .clk_i    (clk_i),
    .ctl_i    (xf_ctl),
    .coord_i  (sel_v),
    .scale_i  (cfg_q[tuvwf_pkg::LightVScale]),
    .origin_i (cfg_q[tuvwf_pkg::LightVOrigin]),
    .result_o (light_v)
  );

  assign out_valid_o             = e_vld_q;
  assign out_word_o.vertex_index = e_idx_q;
  assign out_word_o.tex_u_out    = tex_u;
  assign out_word_o.tex_v_out    = tex_v;
  assign out_word_o.light_u_out  = light_u;
  assign out_word_o.light_v_out  = light_v;
  assign out_word_o.face_fixes   = e_fix_q;
  assign out_word_o.last         = e_last_q;

endmodule

### design/tuvwf_xform.sv
module tuvwf_xform #(
  parameter bit Negate = 1'b0
) (
  input  logic                                    clk_i,
  input  tuvwf_pkg::xf_ctl_t                      ctl_i,
  input  logic signed [tuvwf_pkg::WideWidth-1:0]  coord_i,
  input  logic signed [tuvwf_pkg::CoordWidth-1:0] scale_i,
  input  logic signed [tuvwf_pkg::CoordWidth-1:0] origin_i,
  output logic signed [tuvwf_pkg::CoordWidth-1:0] result_o
);

  localparam int W  = tuvwf_pkg::CoordWidth;
  localparam int F  = tuvwf_pkg::FracBits;
  localparam int DW = tuvwf_pkg::DistWidth;
  localparam int PW = tuvwf_pkg::ProdWidth;
  localparam int SW = tuvwf_pkg::ShiftWidth;

  localparam logic signed [SW:0] SatMax = {{(SW-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW:0] SatMin = {{(SW-W+2){1'b1}}, {(W-1){1'b0}}};

  logic signed [DW-1:0] delta;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] prod_q;
  logic signed [SW:0]   sum;
  logic signed [W-1:0]  sat_d;
  logic signed [W-1:0]  result_q;

  assign delta = $signed({coord_i[W], coord_i}) - tuvwf_pkg::HalfFx;
  assign prod  = $signed({{(PW-W){scale_i[W-1]}}, scale_i}) *
                 $signed({{(PW-DW){delta[DW-1]}}, delta});

  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      prod_q <= prod[PW-1:F];
    end
  end

  always_comb begin
    if (Negate) begin
      sum = $signed({{(SW-W+1){origin_i[W-1]}}, origin_i}) -
            $signed({prod_q[SW-1], prod_q});
    end else begin
      sum = $signed({{(SW-W+1){origin_i[W-1]}}, origin_i}) +
            $signed({prod_q[SW-1], prod_q});
    end
    if (sum > SatMax) begin
      sat_d = SatMax[W-1:0];
    end else if (sum < SatMin) begin
      sat_d = SatMin[W-1:0];
    end else begin
      sat_d = sum[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      result_q <= sat_d;
    end
  end

  assign result_o = result_q;

endmodule
